[hdl/model_specific_register_file_macros.svh]
// ----------------------------------------------------------------------------
// model_specific_register_file_macros.svh
// Assertion macros for the model-specific register file.
// ----------------------------------------------------------------------------
`ifndef MODEL_SPECIFIC_REGISTER_FILE_MACROS_SVH
`define MODEL_SPECIFIC_REGISTER_FILE_MACROS_SVH

`ifndef SYNTHESIS
// checked property, disabled while reset is high
`define MSRF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("msrf assertion failed");
// checked property, also active during reset
`define MSRF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("msrf assertion failed");
`else
`define MSRF_ASSERT(lbl, clk, rst, prop)
`define MSRF_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[hdl/msrf_pkg.sv]
// ----------------------------------------------------------------------------
// msrf_pkg
// Register index map, select codes and decode type of the register file.
// ----------------------------------------------------------------------------
package msrf_pkg;

  localparam int FIXED_RANGE_COUNT    = 32;
  localparam int VARIABLE_RANGE_COUNT = 16;
  localparam int FAST_COUNT           = 3;

  localparam int FIX_IDX_W  = (FIXED_RANGE_COUNT > 1) ? $clog2(FIXED_RANGE_COUNT) : 1;
  localparam int VAR_IDX_W  = (VARIABLE_RANGE_COUNT > 1) ? $clog2(VARIABLE_RANGE_COUNT) : 1;
  localparam int FAST_IDX_W = 2;

  localparam logic [31:0] IDX_INTC_BASE  = 32'h0000_001B;
  localparam logic [31:0] IDX_STAMP      = 32'h0000_0010;
  localparam logic [31:0] IDX_CONST      = 32'h0000_00FE;
  localparam logic [31:0] IDX_FAST_FIRST = 32'h0000_0174;
  localparam logic [31:0] IDX_VAR_FIRST  = 32'h0000_0200;
  localparam logic [31:0] IDX_FIX_FIRST  = 32'h0000_0250;
  localparam logic [31:0] IDX_PAGE_ATTR  = 32'h0000_0277;
  localparam logic [31:0] IDX_DEF_TYPE   = 32'h0000_02FF;
  localparam logic [31:0] IDX_EXT_FEAT   = 32'hC000_0080;
  localparam logic [63:0] CONST_VALUE    = 64'h0000_0000_0000_0508;

  typedef logic [3:0] sel_t;

  localparam sel_t SEL_NONE  = 4'd0;
  localparam sel_t SEL_APIC  = 4'd1;
  localparam sel_t SEL_FAST  = 4'd2;
  localparam sel_t SEL_FIX   = 4'd3;
  localparam sel_t SEL_VAR   = 4'd4;
  localparam sel_t SEL_PAT   = 4'd5;
  localparam sel_t SEL_DEF   = 4'd6;
  localparam sel_t SEL_STAMP = 4'd7;
  localparam sel_t SEL_EXT   = 4'd8;
  localparam sel_t SEL_CONST = 4'd9;

  typedef struct packed {
    logic                  is_write;
    sel_t                  sel;
    logic [FAST_IDX_W-1:0] fast_idx;
    logic [FIX_IDX_W-1:0]  fix_idx;
    logic [VAR_IDX_W-1:0]  var_idx;
  } dec_t;

endpackage

[hdl/model_specific_register_file.sv]
// ----------------------------------------------------------------------------
// model_specific_register_file
// Emulated model-specific register file with stream request/result ports.
// ----------------------------------------------------------------------------
// One request can be taken every clock cycle while the result side is not stalled:
// the request is captured in an input register, decoded and applied to the
// register storage in one pass, and the result is held in an output register
// that drives the result port. Result-side backpressure stalls both stages; the
// input side keeps accepting as long as the output register can drain. Requests
// are applied strictly in order, so a read always sees every earlier write.
module model_specific_register_file (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic         cfg_wdata,      // apic_present
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,        // msr_index, write_high, write_low, cycle_count
  input  logic         s_tuser,        // kind
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [63:0]  m_tdata,        // read_high, read_low
  output logic         m_tuser         // fault
);

  `include "model_specific_register_file_macros.svh"

  logic        s1_valid;
  logic        s1_kind;
  logic [31:0] s1_index;
  logic [31:0] s1_write_high;
  logic [31:0] s1_write_low;
  logic [63:0] s1_cycles;

  logic        out_valid;
  logic [31:0] out_high;
  logic [31:0] out_low;
  logic        out_fault;

  logic        out_free;
  logic        advance;

  msrf_pkg::dec_t dec;
  logic [31:0]    res_high;
  logic [31:0]    res_low;
  logic           res_fault;

  assign out_free = !out_valid || m_tready;
  assign advance  = s1_valid && out_free;
  assign s_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_kind       <= s_tuser;
      s1_index      <= s_tdata[31:0];
      s1_write_high <= s_tdata[63:32];
      s1_write_low  <= s_tdata[95:64];
      s1_cycles     <= s_tdata[159:96];
    end
  end

  msrf_decode u_decode (
    .kind      (s1_kind),
    .msr_index (s1_index),
    .dec       (dec)
  );

  msrf_store u_store (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .commit      (advance),
    .dec         (dec),
    .write_high  (s1_write_high),
    .write_low   (s1_write_low),
    .cycle_count (s1_cycles),
    .read_high   (res_high),
    .read_low    (res_low),
    .fault       (res_fault)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_high  <= res_high;
      out_low   <= res_low;
      out_fault <= res_fault;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_low, out_high};
  assign m_tuser  = out_fault;

  `MSRF_ASSERT(a_fault_zero_data, clk, rst, (m_tvalid && m_tuser) |-> (m_tdata == 64'd0))
  `MSRF_ASSERT(a_stall_only_full, clk, rst, !s_tready |-> (s1_valid && out_valid && !m_tready))
  `MSRF_ASSERT(a_stall_holds_s1, clk, rst, (s1_valid && !advance) |=> s1_valid)
  `MSRF_ASSERT_ALWAYS(a_reset_empty, clk, ($past(rst) && !rst) |-> (!m_tvalid && s_tready))

endmodule

[hdl/msrf_decode.sv]
// ----------------------------------------------------------------------------
// msrf_decode
// Maps a 32-bit register index to a register select and entry number.
// ----------------------------------------------------------------------------
module msrf_decode (
  input  logic               kind,
  input  logic [31:0]        msr_index,
  output msrf_pkg::dec_t     dec
);

  logic [31:0] fast_off;
  logic [31:0] fix_off;
  logic [31:0] var_off;

  assign fast_off = msr_index - msrf_pkg::IDX_FAST_FIRST;
  assign fix_off  = msr_index - msrf_pkg::IDX_FIX_FIRST;
  assign var_off  = msr_index - msrf_pkg::IDX_VAR_FIRST;

  always_comb begin
    dec.is_write = kind;
    dec.fast_idx = fast_off[msrf_pkg::FAST_IDX_W-1:0];
    dec.fix_idx  = fix_off[msrf_pkg::FIX_IDX_W-1:0];
    dec.var_idx  = var_off[msrf_pkg::VAR_IDX_W-1:0];
    if (msr_index == msrf_pkg::IDX_INTC_BASE) begin
      dec.sel = msrf_pkg::SEL_APIC;
    end else if (fast_off < 32'(msrf_pkg::FAST_COUNT)) begin
      dec.sel = msrf_pkg::SEL_FAST;
    end else if (fix_off < 32'(msrf_pkg::FIXED_RANGE_COUNT)) begin
      dec.sel = msrf_pkg::SEL_FIX;
    end else if (var_off < 32'(msrf_pkg::VARIABLE_RANGE_COUNT)) begin
      dec.sel = msrf_pkg::SEL_VAR;
    end else if (msr_index == msrf_pkg::IDX_PAGE_ATTR) begin
      dec.sel = msrf_pkg::SEL_PAT;
    end else if (msr_index == msrf_pkg::IDX_DEF_TYPE) begin
      dec.sel = msrf_pkg::SEL_DEF;
    end else if (msr_index == msrf_pkg::IDX_STAMP) begin
      dec.sel = msrf_pkg::SEL_STAMP;
    end else if (msr_index == msrf_pkg::IDX_EXT_FEAT) begin
      dec.sel = msrf_pkg::SEL_EXT;
    end else if (msr_index == msrf_pkg::IDX_CONST) begin
      dec.sel = msrf_pkg::SEL_CONST;
    end else begin
      dec.sel = msrf_pkg::SEL_NONE;
    end
  end

endmodule

[hdl/msrf_store.sv]
// ----------------------------------------------------------------------------
// msrf_store
// Register storage, read select and write update for one decoded request.
// ----------------------------------------------------------------------------
module msrf_store (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic           cfg_wdata,
  input  logic           commit,
  input  msrf_pkg::dec_t dec,
  input  logic [31:0]    write_high,
  input  logic [31:0]    write_low,
  input  logic [63:0]    cycle_count,
  output logic [31:0]    read_high,
  output logic [31:0]    read_low,
  output logic           fault
);

  logic        apic_present;
  logic [63:0] intc_base_reg;
  logic [31:0] fast_call_regs [msrf_pkg::FAST_COUNT];
  logic [63:0] fixed_range_regs [msrf_pkg::FIXED_RANGE_COUNT];
  logic [63:0] variable_range_regs [msrf_pkg::VARIABLE_RANGE_COUNT];
  logic [63:0] page_attr_reg;
  logic [63:0] default_type_reg;
  logic [63:0] ext_feature_reg;
  logic [63:0] stamp_offset;

  logic [63:0] wval;
  logic [63:0] rval;
  logic        rfault;

  assign wval = {write_high, write_low};

  always_comb begin
    rval   = 64'd0;
    rfault = 1'b0;
    case (dec.sel)
      msrf_pkg::SEL_APIC: begin
        if (apic_present) begin
          rval = intc_base_reg;
        end else begin
          rfault = 1'b1;
        end
      end
      msrf_pkg::SEL_FAST:  rval = {32'd0, fast_call_regs[dec.fast_idx]};
      msrf_pkg::SEL_FIX:   rval = fixed_range_regs[dec.fix_idx];
      msrf_pkg::SEL_VAR:   rval = variable_range_regs[dec.var_idx];
      msrf_pkg::SEL_PAT:   rval = page_attr_reg;
      msrf_pkg::SEL_DEF:   rval = default_type_reg;
      msrf_pkg::SEL_STAMP: rval = cycle_count - stamp_offset;
      msrf_pkg::SEL_EXT:   rval = ext_feature_reg;
      msrf_pkg::SEL_CONST: rval = msrf_pkg::CONST_VALUE;
      default:             rval = 64'd0;
    endcase
    if (dec.is_write) begin
      rval   = 64'd0;
      rfault = 1'b0;
    end
  end

  assign read_high = rval[63:32];
  assign read_low  = rval[31:0];
  assign fault     = rfault;

  always_ff @(posedge clk) begin
    if (rst) begin
      apic_present <= 1'b1;
    end else if (cfg_we) begin
      apic_present <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      intc_base_reg    <= 64'd0;
      page_attr_reg    <= 64'd0;
      default_type_reg <= 64'd0;
      ext_feature_reg  <= 64'd0;
      stamp_offset     <= 64'd0;
      for (int i = 0; i < msrf_pkg::FAST_COUNT; i++) begin
        fast_call_regs[i] <= 32'd0;
      end
      for (int i = 0; i < msrf_pkg::FIXED_RANGE_COUNT; i++) begin
        fixed_range_regs[i] <= 64'd0;
      end
      for (int i = 0; i < msrf_pkg::VARIABLE_RANGE_COUNT; i++) begin
        variable_range_regs[i] <= 64'd0;
      end
    end else if (commit && dec.is_write) begin
      case (dec.sel)
        msrf_pkg::SEL_APIC:  intc_base_reg <= wval;
        msrf_pkg::SEL_FAST:  fast_call_regs[dec.fast_idx] <= write_low;
        msrf_pkg::SEL_FIX:   fixed_range_regs[dec.fix_idx] <= wval;
        msrf_pkg::SEL_VAR:   variable_range_regs[dec.var_idx] <= wval;
        msrf_pkg::SEL_PAT:   page_attr_reg <= wval;
        msrf_pkg::SEL_DEF:   default_type_reg <= wval;
        msrf_pkg::SEL_STAMP: stamp_offset <= cycle_count - wval;
        msrf_pkg::SEL_EXT:   ext_feature_reg <= wval;
        default: ;
      endcase
    end
  end

endmodule

[dv/model_specific_register_file_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// model_specific_register_file_tb
// Self-checking bench for the register file. A shadow copy of every register
// predicts each access reply; replies are compared in order, field by field.
// Directed accesses hit each register kind, range edges and special indexes,
// then random traffic runs with the controller flag toggled between phases.
// ----------------------------------------------------------------------------
module model_specific_register_file_tb;

  localparam bit KIND_READ  = 1'b0;
  localparam bit KIND_WRITE = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 270;

  typedef struct {
    logic [31:0] read_high;
    logic [31:0] read_low;
    logic        fault;
  } reply_t;

  class msr_shadow;
    bit          apic_present;
    logic [63:0] intc_base;
    logic [31:0] fast_call[msrf_pkg::FAST_COUNT];
    logic [63:0] fixed_range[msrf_pkg::FIXED_RANGE_COUNT];
    logic [63:0] var_range[msrf_pkg::VARIABLE_RANGE_COUNT];
    logic [63:0] page_attr;
    logic [63:0] default_type;
    logic [63:0] ext_feature;
    logic [63:0] stamp_offset;
    reply_t      expected_q[$];
    int          errors;
    int          replies;
    int          faults;

    function new();
      apic_present = 1'b1;
      intc_base    = '0;
      foreach (fast_call[i]) fast_call[i] = '0;
      foreach (fixed_range[i]) fixed_range[i] = '0;
      foreach (var_range[i]) var_range[i] = '0;
      page_attr    = '0;
      default_type = '0;
      ext_feature  = '0;
      stamp_offset = '0;
      errors = 0;
      replies = 0;
      faults = 0;
    endfunction

    function void note_request(bit kind, logic [31:0] idx, logic [31:0] wr_high,
                               logic [31:0] wr_low, logic [63:0] cycles);
      logic [63:0] wval;
      logic [63:0] rval;
      reply_t      exp;
      bit          in_fast;
      bit          in_fix;
      bit          in_var;
      wval = {wr_high, wr_low};
      rval = '0;
      exp.fault = 1'b0;
      in_fast = idx >= msrf_pkg::IDX_FAST_FIRST &&
                idx < msrf_pkg::IDX_FAST_FIRST + msrf_pkg::FAST_COUNT;
      in_fix  = idx >= msrf_pkg::IDX_FIX_FIRST &&
                idx < msrf_pkg::IDX_FIX_FIRST + msrf_pkg::FIXED_RANGE_COUNT;
      in_var  = idx >= msrf_pkg::IDX_VAR_FIRST &&
                idx < msrf_pkg::IDX_VAR_FIRST + msrf_pkg::VARIABLE_RANGE_COUNT;
      if (kind == KIND_WRITE) begin
        if (idx == msrf_pkg::IDX_INTC_BASE) begin
          intc_base = wval;
        end else if (in_fast) begin
          fast_call[int'(idx - msrf_pkg::IDX_FAST_FIRST)] = wr_low;
        end else if (in_fix) begin
          fixed_range[int'(idx - msrf_pkg::IDX_FIX_FIRST)] = wval;
        end else if (in_var) begin
          var_range[int'(idx - msrf_pkg::IDX_VAR_FIRST)] = wval;
        end else if (idx == msrf_pkg::IDX_PAGE_ATTR) begin
          page_attr = wval;
        end else if (idx == msrf_pkg::IDX_DEF_TYPE) begin
          default_type = wval;
        end else if (idx == msrf_pkg::IDX_STAMP) begin
          stamp_offset = cycles - wval;
        end else if (idx == msrf_pkg::IDX_EXT_FEAT) begin
          ext_feature = wval;
        end
      end else begin
        if (idx == msrf_pkg::IDX_INTC_BASE) begin
          if (apic_present) rval = intc_base;
          else exp.fault = 1'b1;
        end else if (in_fast) begin
          rval = {32'h0, fast_call[int'(idx - msrf_pkg::IDX_FAST_FIRST)]};
        end else if (in_fix) begin
          rval = fixed_range[int'(idx - msrf_pkg::IDX_FIX_FIRST)];
        end else if (in_var) begin
          rval = var_range[int'(idx - msrf_pkg::IDX_VAR_FIRST)];
        end else if (idx == msrf_pkg::IDX_PAGE_ATTR) begin
          rval = page_attr;
        end else if (idx == msrf_pkg::IDX_DEF_TYPE) begin
          rval = default_type;
        end else if (idx == msrf_pkg::IDX_CONST) begin
          rval = msrf_pkg::CONST_VALUE;
        end else if (idx == msrf_pkg::IDX_STAMP) begin
          rval = cycles - stamp_offset;
        end else if (idx == msrf_pkg::IDX_EXT_FEAT) begin
          rval = ext_feature;
        end
      end
      exp.read_high = rval[63:32];
      exp.read_low  = rval[31:0];
      expected_q.push_back(exp);
    endfunction

    function void check_reply(logic [63:0] data, logic fault_bit);
      reply_t exp;
      replies++;
      if (fault_bit === 1'b1) faults++;
      if (expected_q.size() == 0) begin
        $display("%0t: reply with nothing pending: data=%h fault=%b", $time, data, fault_bit);
        errors++;
        return;
      end
      exp = expected_q.pop_front();
      if (data[31:0] !== exp.read_high) begin
        $display("%0t: read_high expected %h got %h", $time, exp.read_high, data[31:0]);
        errors++;
      end
      if (data[63:32] !== exp.read_low) begin
        $display("%0t: read_low expected %h got %h", $time, exp.read_low, data[63:32]);
        errors++;
      end
      if (fault_bit !== exp.fault) begin
        $display("%0t: fault expected %b got %b", $time, exp.fault, fault_bit);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_wdata = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [159:0] s_tdata = '0;   // msr_index, write_high, write_low, cycle_count
  logic         s_tuser = 1'b0; // kind
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;        // read_high, read_low
  logic         m_tuser;        // fault

  msr_shadow   shadow = new();
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          stall_left = 0;
  int          cycle_no = 0;
  int          sent = 0;
  logic [63:0] tick = '0;

  model_specific_register_file u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // result side: check accepted replies, stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) shadow.check_reply(m_tdata, m_tuser);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic access(bit kind, logic [31:0] idx, logic [31:0] wr_high,
                        logic [31:0] wr_low, logic [63:0] cycles);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {cycles, wr_low, wr_high, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    shadow.note_request(kind, idx, wr_high, wr_low, cycles);
    sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (shadow.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_apic_present(bit present);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= present;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow.apic_present = present;
  endtask

  function automatic logic [31:0] pick_index();
    int r;
    logic [31:0] edges[18];
    edges = '{32'h173, 32'h177, 32'h1FF, 32'h210, 32'h24F, 32'h270, 32'h276, 32'h278,
              32'h2FE, 32'h300, 32'hF, 32'h11, 32'h1A, 32'h1C, 32'hFD, 32'hFF,
              32'hC000007F, 32'hC0000081};
    r = $urandom_range(0, 99);
    if (r < 8) return msrf_pkg::IDX_INTC_BASE;
    if (r < 16) begin
      return msrf_pkg::IDX_FAST_FIRST + $urandom_range(0, msrf_pkg::FAST_COUNT - 1);
    end
    if (r < 34) begin
      return msrf_pkg::IDX_FIX_FIRST + $urandom_range(0, msrf_pkg::FIXED_RANGE_COUNT - 1);
    end
    if (r < 48) begin
      return msrf_pkg::IDX_VAR_FIRST + $urandom_range(0, msrf_pkg::VARIABLE_RANGE_COUNT - 1);
    end
    if (r < 54) return msrf_pkg::IDX_PAGE_ATTR;
    if (r < 60) return msrf_pkg::IDX_DEF_TYPE;
    if (r < 72) return msrf_pkg::IDX_STAMP;
    if (r < 76) return msrf_pkg::IDX_CONST;
    if (r < 82) return msrf_pkg::IDX_EXT_FEAT;
    if (r < 92) return edges[$urandom_range(0, 17)];
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  function automatic logic [63:0] pick_cycles();
    if ($urandom_range(0, 3) == 0) return {$urandom(), $urandom()};
    tick = tick + $urandom_range(1, 64);
    return tick;
  endfunction

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    set_apic_present(1'b1);

    // directed: each register kind, range edges and special indexes
    access(KIND_READ,  msrf_pkg::IDX_CONST, '1, '1, 64'd0);
    access(KIND_WRITE, msrf_pkg::IDX_CONST, '1, '1, 64'd1);
    access(KIND_READ,  msrf_pkg::IDX_CONST, '0, '0, 64'd2);
    access(KIND_READ,  msrf_pkg::IDX_INTC_BASE, '0, '0, 64'd3);
    access(KIND_WRITE, msrf_pkg::IDX_INTC_BASE, '1, '1, 64'd4);
    access(KIND_READ,  msrf_pkg::IDX_INTC_BASE, '0, '0, 64'd5);
    access(KIND_WRITE, msrf_pkg::IDX_FAST_FIRST, '1, 32'h1234_5678, 64'd6);
    access(KIND_READ,  msrf_pkg::IDX_FAST_FIRST, '1, '1, 64'd7);
    access(KIND_WRITE, msrf_pkg::IDX_FAST_FIRST + 2, 32'hDEAD_BEEF, '1, 64'd8);
    access(KIND_READ,  msrf_pkg::IDX_FAST_FIRST + 2, '0, '0, 64'd9);
    access(KIND_WRITE, msrf_pkg::IDX_FIX_FIRST, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 64'd10);
    access(KIND_WRITE, msrf_pkg::IDX_FIX_FIRST + msrf_pkg::FIXED_RANGE_COUNT - 1,
           '1, '0, 64'd11);
    access(KIND_WRITE, msrf_pkg::IDX_FIX_FIRST + msrf_pkg::FIXED_RANGE_COUNT,
           '1, '1, 64'd12);
    access(KIND_READ,  msrf_pkg::IDX_FIX_FIRST + msrf_pkg::FIXED_RANGE_COUNT - 1,
           '0, '0, 64'd13);
    access(KIND_READ,  msrf_pkg::IDX_FIX_FIRST + msrf_pkg::FIXED_RANGE_COUNT,
           '0, '0, 64'd14);
    access(KIND_WRITE, msrf_pkg::IDX_VAR_FIRST + msrf_pkg::VARIABLE_RANGE_COUNT - 1,
           '0, '1, 64'd15);
    access(KIND_WRITE, msrf_pkg::IDX_VAR_FIRST + msrf_pkg::VARIABLE_RANGE_COUNT,
           '1, '1, 64'd16);
    access(KIND_READ,  msrf_pkg::IDX_VAR_FIRST + msrf_pkg::VARIABLE_RANGE_COUNT - 1,
           '0, '0, 64'd17);
    access(KIND_WRITE, msrf_pkg::IDX_PAGE_ATTR, 32'h0007_0406, 32'h0007_0406, 64'd18);
    access(KIND_WRITE, msrf_pkg::IDX_DEF_TYPE, 32'h8000_0000, 32'h0000_0C06, 64'd19);
    access(KIND_WRITE, msrf_pkg::IDX_EXT_FEAT, 32'h0000_0001, 32'h0000_0D01, 64'd20);
    access(KIND_READ,  msrf_pkg::IDX_EXT_FEAT, '0, '0, 64'd21);
    // offset wraps past zero, then reads at both ends of the counter
    access(KIND_WRITE, msrf_pkg::IDX_STAMP, 32'h0, 32'h100, 64'h10);
    access(KIND_READ,  msrf_pkg::IDX_STAMP, '0, '0, 64'h0);
    access(KIND_READ,  msrf_pkg::IDX_STAMP, '0, '0, '1);
    access(KIND_READ,  32'hFFFF_FFFF, '1, '1, 64'd22);
    access(KIND_WRITE, 32'h0, '1, '1, 64'd23);
    access(KIND_READ,  32'h0, '0, '0, 64'd24);

    for (int p = 0; p < PHASES; p++) begin
      set_apic_present(p[0]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          gaps_on   = (p != 2) && ($urandom_range(0, 3) != 0);
          stalls_on = (p != 2) && ($urandom_range(0, 3) != 0);
        end
        access(1'($urandom_range(0, 1)), pick_index(), pick_word(), pick_word(),
               pick_cycles());
      end
    end

    s_tvalid <= 1'b0;
    while (shadow.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.expected_q.size() != 0) begin
      $display("%0t: %0d replies never arrived", $time, shadow.expected_q.size());
      shadow.errors++;
    end
    $display("Ran %0d register accesses, %0d replies checked, %0d faulting base reads,",
             sent, shadow.replies, shadow.faults);
    $display("across %0d controller-flag phases with random gaps and result stalls.",
             PHASES + 1);
    if (shadow.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
